// ===== rtl/lcc_pkg.sv =====
`timescale 1ns / 1ps

package lcc_pkg;

   // strip and comet geometry
   localparam int TAIL_LENGTH  = 20;
   localparam int STRIP_PIXELS = 128;

   // field widths
   localparam int COLOR_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int INDEX_W   = 7;
   localparam int HEAD_W    = 8;
   localparam int END_W     = 7;
   localparam int TAIL_W    = $clog2(TAIL_LENGTH + 1);
   localparam int ADDR_W    = $clog2(STRIP_PIXELS);
   localparam int POS_W     = 12;

   // scaling by k / TAIL_LENGTH: exact floor through a rounded-up reciprocal,
   // valid while 255 * TAIL_LENGTH * TAIL_LENGTH stays below 2**DIV_SHIFT
   localparam int PROD_W    = $clog2(255 * TAIL_LENGTH + 1);
   localparam int DIV_SHIFT = 17;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int RECIP     = ((2 ** DIV_SHIFT) + TAIL_LENGTH - 1) / TAIL_LENGTH;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_BASE_COLOR   = 2'd0,
      REG_END_POSITION = 2'd1,
      REG_DIRECTION    = 2'd2
   } lcc_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } lcc_state_type;

   typedef struct packed {
      logic [COLOR_W-1:0] base_color;
      logic [END_W-1:0]   end_position;
      logic               direction;
   } lcc_cfg_type;

   typedef struct packed {
      logic              load;
      logic              add;
      logic [TAIL_W-1:0] k;
   } lcc_tail_ctrl_type;

   // run is over once the head has moved past the end plus the tail
   function automatic logic lcc_done(logic [HEAD_W-1:0] head, logic [END_W-1:0] end_pos);
      logic [HEAD_W:0] limit;
      limit = (HEAD_W + 1)'(end_pos) + (HEAD_W + 1)'(TAIL_LENGTH);
      return {1'b0, head} > limit;
   endfunction

endpackage

// ===== rtl/lcc_req_if.sv =====
`timescale 1ns / 1ps

interface lcc_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink (input valid, input tick, output ready);
endinterface

// ===== rtl/lcc_rsp_if.sv =====
`timescale 1ns / 1ps

interface lcc_rsp_if import lcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               pixel_valid;
   logic [INDEX_W-1:0] pixel_index;
   logic [COLOR_W-1:0] pixel_color;
   logic               last;
   logic               run_done;

   modport source (
      output valid, output pixel_valid, output pixel_index, output pixel_color,
      output last, output run_done, input ready
   );
   modport sink (
      input valid, input pixel_valid, input pixel_index, input pixel_color,
      input last, input run_done, output ready
   );
endinterface

// ===== rtl/lcc_ram.sv =====
`timescale 1ns / 1ps

module lcc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lcc_tail_unit.sv =====
`timescale 1ns / 1ps

module lcc_tail_unit import lcc_pkg::*; (
   input  logic               clock,
   input  lcc_tail_ctrl_type  ctrl,
   input  logic [COLOR_W-1:0] base_color,
   input  logic [COLOR_W-1:0] prior_rgb,
   output logic [COLOR_W-1:0] result_rgb
);

   localparam int FULL_W = PROD_W + RECIP_W;

   logic [2:0][PROD_W-1:0] prod_ff;
   logic [2:0][PROD_W-1:0] prod_in;
   logic [2:0][CHAN_W-1:0] scale;
   logic [2:0][CHAN_W-1:0] mixed;

   // first stage: each channel byte times the weight k
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = PROD_W'(base_color[c*CHAN_W +: CHAN_W]) * PROD_W'(ctrl.k);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   // second stage: divide by the tail length, then add or subtract modulo 256
   always_comb begin
      logic [FULL_W-1:0] full;
      for (int c = 0; c < 3; c++) begin
         full     = FULL_W'(prod_ff[c]) * FULL_W'(RECIP);
         scale[c] = full[DIV_SHIFT +: CHAN_W];
         mixed[c] = ctrl.add ? (prior_rgb[c*CHAN_W +: CHAN_W] + scale[c])
                             : (prior_rgb[c*CHAN_W +: CHAN_W] - scale[c]);
      end
   end

   assign result_rgb = mixed;

endmodule

// ===== rtl/lcc_csr.sv =====
`timescale 1ns / 1ps

module lcc_csr import lcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output lcc_cfg_type           cfg
);

   lcc_cfg_type cfg_ff;
   logic        wr_strobe;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite;

   // write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_color   <= COLOR_W'(24'hFF0000);
         cfg_ff.end_position <= END_W'(50);
         cfg_ff.direction    <= 1'b0;
      end else if (wr_strobe) begin
         case (paddr[3:2])
            REG_BASE_COLOR:   cfg_ff.base_color   <= pwdata[COLOR_W-1:0];
            REG_END_POSITION: cfg_ff.end_position <= pwdata[END_W-1:0];
            REG_DIRECTION:    cfg_ff.direction    <= pwdata[0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (paddr[3:2])
         REG_BASE_COLOR:   prdata = CSR_DATA_W'(cfg_ff.base_color);
         REG_END_POSITION: prdata = CSR_DATA_W'(cfg_ff.end_position);
         REG_DIRECTION:    prdata = CSR_DATA_W'(cfg_ff.direction);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/led_comet_tail_chaser_unit.sv =====
`timescale 1ns / 1ps

// Comet chaser over a 128-pixel RGB frame buffer. Each transfer with tick=1
// runs one frame step: the old tail is removed, the head advances and the new
// tail is drawn (the first step only draws), every on-strip tail pixel a
// read-modify-write of the buffer that gives one result transfer (last marks
// the final one of the step; a step without pixel writes gives one status
// transfer). The block takes one tick at a time: a step walks one or two
// passes of TAIL_LENGTH entries, reading each on-strip pixel in the scan
// state and writing it back in the update state, through buffer read and
// write ports that share one address. Stalls on the result side can hold
// a step in its update or finish state. The buffer is dark right after
// reset through per-pixel valid bits, with no clearing pass; configuration
// is read live at every step.
module led_comet_tail_chaser_unit import lcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lcc_req_if.sink               req_chan,
   lcc_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   lcc_cfg_type       cfg;
   lcc_tail_ctrl_type tail_ctrl;
   lcc_state_type     state_ff, state_in;

   logic              started_ff;
   logic [HEAD_W-1:0] head_ff;
   logic [TAIL_W-1:0] idx_ff;
   logic              add_ff;
   logic              draw_after_ff;
   logic              done_ff;

   logic               pend_valid_ff;
   logic [INDEX_W-1:0] pend_index_ff;
   logic [COLOR_W-1:0] pend_color_ff;

   logic               out_valid_ff;
   logic               out_pixel_valid_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic               out_last_ff;
   logic               out_done_ff;

   logic [STRIP_PIXELS-1:0] pix_valid_ff;
   logic                    rd_valid_ff;

   logic [POS_W-1:0]   pos;
   logic               in_strip;
   logic [ADDR_W-1:0]  pix_addr;
   logic [COLOR_W-1:0] rd_data;
   logic [COLOR_W-1:0] prior_rgb;
   logic [COLOR_W-1:0] mixed_rgb;
   logic [HEAD_W-1:0]  head_next;
   logic               done_now;
   logic               done_next;
   logic               end_of_pass;
   logic               pass_next;
   logic               out_free;

   logic accept_tick;
   logic scan_hit;
   logic push;
   logic advance;
   logic finish_go;

   // configuration registers
   lcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // tail entry position and strip bounds
   always_comb begin
      logic [POS_W-1:0] head_ext;
      logic [POS_W-1:0] idx_ext;
      head_ext = POS_W'(head_ff);
      idx_ext  = POS_W'(idx_ff);
      pos      = cfg.direction ? (head_ext + idx_ext) : (head_ext - idx_ext);
      in_strip = !pos[POS_W-1] && (pos < POS_W'(STRIP_PIXELS));
   end

   assign pix_addr    = pos[ADDR_W-1:0];
   assign head_next   = head_ff + HEAD_W'(1);
   assign done_now    = lcc_done(head_ff, cfg.end_position);
   assign done_next   = lcc_done(head_next, cfg.end_position);
   assign end_of_pass = idx_ff == TAIL_W'(TAIL_LENGTH - 1);
   assign pass_next   = !add_ff && draw_after_ff;
   assign out_free    = !out_valid_ff || rsp_chan.ready;

   // frame buffer
   lcc_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (STRIP_PIXELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (pix_addr),
      .wr_data (mixed_rgb),
      .rd_addr (pix_addr),
      .rd_data (rd_data)
   );

   // pixels never written read as dark
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= '0;
      end else if (push) begin
         pix_valid_ff[pix_addr] <= 1'b1;
      end
      rd_valid_ff <= pix_valid_ff[pix_addr];
   end

   assign prior_rgb = rd_valid_ff ? rd_data : '0;

   // shared scale and mix unit
   assign tail_ctrl.load = scan_hit;
   assign tail_ctrl.add  = add_ff;
   assign tail_ctrl.k    = TAIL_W'(TAIL_LENGTH) - idx_ff;

   lcc_tail_unit u_tail (
      .clock      (clock),
      .ctrl       (tail_ctrl),
      .base_color (cfg.base_color),
      .prior_rgb  (prior_rgb),
      .result_rgb (mixed_rgb)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid && req_chan.tick) begin
               state_in = done_now ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (in_strip) begin
               state_in = ST_UPDATE;
            end else if (end_of_pass && !pass_next) begin
               state_in = ST_FINISH;
            end
         end
         ST_UPDATE: begin
            if (out_free || !pend_valid_ff) begin
               state_in = (end_of_pass && !pass_next) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer strobes
   always_comb begin
      accept_tick = 1'b0;
      scan_hit    = 1'b0;
      push        = 1'b0;
      advance     = 1'b0;
      finish_go   = 1'b0;
      case (state_ff)
         ST_IDLE:   accept_tick = req_chan.valid && req_chan.tick;
         ST_SCAN: begin
            scan_hit = in_strip;
            advance  = !in_strip;
         end
         ST_UPDATE: begin
            push    = out_free || !pend_valid_ff;
            advance = push;
         end
         ST_FINISH: finish_go = out_free;
         default: ;
      endcase
   end

   assign req_chan.ready = state_ff == ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // step bookkeeping: head, tail entry, pass
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         head_ff       <= '0;
         idx_ff        <= '0;
         add_ff        <= 1'b0;
         draw_after_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else if (accept_tick) begin
         started_ff    <= 1'b1;
         idx_ff        <= '0;
         add_ff        <= !started_ff;
         draw_after_ff <= started_ff && !done_next;
         done_ff       <= (started_ff && !done_now) ? done_next : done_now;
      end else if (advance) begin
         if (end_of_pass) begin
            idx_ff <= '0;
            add_ff <= 1'b1;
            if (!add_ff) begin
               head_ff <= head_next;
            end
         end else begin
            idx_ff <= idx_ff + TAIL_W'(1);
         end
      end
   end

   // hold back one pixel result so the final one can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (push) begin
         pend_valid_ff <= 1'b1;
      end else if (finish_go) begin
         pend_valid_ff <= 1'b0;
      end
      if (push) begin
         pend_index_ff <= pos[INDEX_W-1:0];
         pend_color_ff <= mixed_rgb;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((push && pend_valid_ff) || finish_go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (push && pend_valid_ff) begin
         out_pixel_valid_ff <= 1'b1;
         out_index_ff       <= pend_index_ff;
         out_color_ff       <= pend_color_ff;
         out_last_ff        <= 1'b0;
         out_done_ff        <= done_ff;
      end else if (finish_go) begin
         out_pixel_valid_ff <= pend_valid_ff;
         out_index_ff       <= pend_valid_ff ? pend_index_ff : '0;
         out_color_ff       <= pend_valid_ff ? pend_color_ff : '0;
         out_last_ff        <= 1'b1;
         out_done_ff        <= done_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_valid = out_pixel_valid_ff;
   assign rsp_chan.pixel_index = out_index_ff;
   assign rsp_chan.pixel_color = out_color_ff;
   assign rsp_chan.last        = out_last_ff;
   assign rsp_chan.run_done    = out_done_ff;

`ifndef NO_ASSERTIONS
   // nothing is held back between steps
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending pixel result left over at end of step");

   // a status transfer always closes its step
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.pixel_valid) |-> rsp_chan.last)
      else $error("status transfer without last");

   // an accepted tick always starts work
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.tick) |=> (state_ff != ST_IDLE))
      else $error("accepted tick did not start a step");

   // a buffer write only follows a read of the same pixel
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      push |-> $past(scan_hit) || $past(state_ff == ST_UPDATE))
      else $error("buffer write without a preceding read");
`endif

endmodule

// ===== sim/tb_led_comet_tail_chaser_unit.sv =====
`timescale 1ns / 1ps

module tb_led_comet_tail_chaser_unit import lcc_pkg::*; ();

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 200;
   localparam int STALL_LIMIT   = 4000;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 25;
   localparam int MAX_REPORTS   = 100;

   typedef struct {
      logic               pixel_valid;
      logic [INDEX_W-1:0] pixel_index;
      logic [COLOR_W-1:0] pixel_color;
      logic               last;
      logic               run_done;
   } pixel_write_type;

   typedef struct {
      logic tick;
      logic drain_first;
   } tick_item_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lcc_req_if req_chan ();
   lcc_rsp_if rsp_chan ();

   led_comet_tail_chaser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // shadow of the frame buffer, head and live settings
   logic [COLOR_W-1:0] strip_shadow [STRIP_PIXELS];
   logic [HEAD_W-1:0]  head_shadow = '0;
   logic               started_shadow = 1'b0;
   logic [COLOR_W-1:0] base_shadow = 24'hff0000;
   logic [END_W-1:0]   end_shadow = 7'd50;
   logic               dir_shadow = 1'b0;

   tick_item_type   pending_ticks [$];
   pixel_write_type step_writes [$];
   pixel_write_type expected_writes [$];
   pixel_write_type oldest_write;
   tick_item_type   next_tick;

   int predicted_total = 0;
   int checked_total = 0;
   int new_results = 0;
   int error_count = 0;
   int items_accepted = 0;
   int ticks_accepted = 0;
   int status_seen = 0;
   int csr_writes = 0;
   int head_peak = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left = 0;
   int stall_cycles = 0;
   logic hold_arm;

   initial begin
      for (int p = 0; p < STRIP_PIXELS; p++) begin
         strip_shadow[p] = '0;
      end
   end

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // scale every channel of the base color by (TAIL_LENGTH - entry) / TAIL_LENGTH
   function automatic logic [COLOR_W-1:0] fade_color(int entry);
      logic [COLOR_W-1:0] faded;
      int unsigned chan;
      int unsigned weight;
      int sh;
      faded = '0;
      weight = TAIL_LENGTH - entry;
      for (sh = 0; sh < COLOR_W; sh += CHAN_W) begin
         chan = 32'(base_shadow[sh +: CHAN_W]);
         faded[sh +: CHAN_W] = CHAN_W'((chan * weight) / TAIL_LENGTH);
      end
      return faded;
   endfunction

   // per-channel add or subtract, wrapping at 8 bits
   function automatic logic [COLOR_W-1:0] blend_color(logic [COLOR_W-1:0] prior,
                                                      logic [COLOR_W-1:0] delta,
                                                      logic add);
      logic [COLOR_W-1:0] blended;
      int sh;
      for (sh = 0; sh < COLOR_W; sh += CHAN_W) begin
         blended[sh +: CHAN_W] = add ? prior[sh +: CHAN_W] + delta[sh +: CHAN_W]
                                     : prior[sh +: CHAN_W] - delta[sh +: CHAN_W];
      end
      return blended;
   endfunction

   function automatic logic run_over();
      return int'(head_shadow) > int'(end_shadow) + TAIL_LENGTH;
   endfunction

   // draw or erase the tail at the current head, skipping off-strip entries
   function automatic void sweep_tail(logic add);
      pixel_write_type w;
      int entry;
      int pos;
      for (entry = 0; entry < TAIL_LENGTH; entry++) begin
         pos = dir_shadow ? int'(head_shadow) + entry : int'(head_shadow) - entry;
         if (pos >= 0 && pos < STRIP_PIXELS) begin
            strip_shadow[pos] = blend_color(strip_shadow[pos], fade_color(entry), add);
            w.pixel_valid = 1'b1;
            w.pixel_index = INDEX_W'(pos);
            w.pixel_color = strip_shadow[pos];
            w.last = 1'b0;
            w.run_done = 1'b0;
            step_writes.insert(step_writes.size(), w);
         end
      end
   endfunction

   // advance the shadow one frame and queue the pixel writes it causes
   function automatic int predict_frame(logic tick);
      pixel_write_type status;
      logic done;
      int k;
      if (!tick) return 0;
      step_writes.delete();
      if (started_shadow) begin
         if (!run_over()) begin
            sweep_tail(1'b0);
            head_shadow = head_shadow + HEAD_W'(1);
            if (!run_over()) sweep_tail(1'b1);
         end
      end else begin
         started_shadow = 1'b1;
         if (!run_over()) sweep_tail(1'b1);
      end
      done = run_over();
      // a frame without pixel writes still reports its status
      if (step_writes.size() == 0) begin
         status.pixel_valid = 1'b0;
         status.pixel_index = '0;
         status.pixel_color = '0;
         status.last = 1'b0;
         status.run_done = 1'b0;
         step_writes.insert(step_writes.size(), status);
      end
      for (k = 0; k < step_writes.size(); k++) begin
         step_writes[k].run_done = done;
      end
      step_writes[step_writes.size() - 1].last = 1'b1;
      for (k = 0; k < step_writes.size(); k++) begin
         expected_writes.insert(expected_writes.size(), step_writes[k]);
      end
      if (int'(head_shadow) > head_peak) head_peak = int'(head_shadow);
      return step_writes.size();
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned want_v,
                                  input longint unsigned got_v);
      if (error_count < MAX_REPORTS) begin
         $display("mismatch at result %0d, %s: expected 0x%0h, got 0x%0h",
                  checked_total, what, want_v, got_v);
      end
      error_count++;
   endtask

   task automatic add_tick(input logic tick, input logic drain_first);
      tick_item_type item;
      item.tick = tick;
      item.drain_first = drain_first;
      pending_ticks.insert(pending_ticks.size(), item);
   endtask

   // queue random items away from the clock edge
   task automatic add_random_ticks(input int count, input int zero_pct, input int drain_pct);
      @(negedge clock);
      repeat (count) begin
         add_tick($urandom_range(0, 99) >= zero_pct, $urandom_range(0, 99) < drain_pct);
      end
   endtask

   // wait until all items are sent, all results are in and the block has settled
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_chan.valid || predicted_total != checked_total);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one register over the APB port, then read it back
   task automatic csr_write(input lcc_reg_type which, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] mask;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {which, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      case (which)
         REG_BASE_COLOR: begin
            mask = (1 << COLOR_W) - 1;
            base_shadow = value[COLOR_W-1:0];
         end
         REG_END_POSITION: begin
            mask = (1 << END_W) - 1;
            end_shadow = value[END_W-1:0];
         end
         default: begin
            mask = 1;
            dir_shadow = value[0];
         end
      endcase
      csr_writes++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      if ((prdata & mask) !== (value & mask)) begin
         report_mismatch("register readback", value & mask, prdata & mask);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // driver: offer queued ticks, predict each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.tick <= 1'b0;
      end else begin
         new_results = 0;
         if (req_chan.valid && req_chan.ready) begin
            new_results = predict_frame(req_chan.tick);
            predicted_total <= predicted_total + new_results;
            items_accepted++;
            if (req_chan.tick) ticks_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                (!pending_ticks[0].drain_first ||
                 predicted_total + new_results == checked_total)) begin
               next_tick = pending_ticks.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.tick <= next_tick.tick;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_writes.size() == 0) begin
               report_mismatch("result with nothing expected", 0, rsp_chan.pixel_index);
            end else begin
               oldest_write = expected_writes.pop_front();
               if (rsp_chan.pixel_valid !== oldest_write.pixel_valid)
                  report_mismatch("pixel_valid", oldest_write.pixel_valid, rsp_chan.pixel_valid);
               if (rsp_chan.pixel_index !== oldest_write.pixel_index)
                  report_mismatch("pixel_index", oldest_write.pixel_index, rsp_chan.pixel_index);
               if (rsp_chan.pixel_color !== oldest_write.pixel_color)
                  report_mismatch("pixel_color", oldest_write.pixel_color, rsp_chan.pixel_color);
               if (rsp_chan.last !== oldest_write.last)
                  report_mismatch("last", oldest_write.last, rsp_chan.last);
               if (rsp_chan.run_done !== oldest_write.run_done)
                  report_mismatch("run_done", oldest_write.run_done, rsp_chan.run_done);
               if (!oldest_write.pixel_valid) status_seen++;
               checked_total <= checked_total + 1;
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off, started on request and counted down here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      int phase;
      logic [COLOR_W-1:0] color_pick;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.tick = 1'b0;
      rsp_chan.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      hold_arm = 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 47;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle tick, first draw at head 0 with most of the tail off the strip
      @(negedge clock);
      add_tick(1'b0, 1'b0);
      add_tick(1'b1, 1'b0);
      add_tick(1'b1, 1'b0);
      add_tick(1'b0, 1'b0);
      add_tick(1'b1, 1'b0);
      add_tick(1'b1, 1'b1);
      wait_quiet();

      // full white with the tail turned ahead while the old tail is still drawn
      csr_write(REG_BASE_COLOR, 24'hffffff);
      csr_write(REG_DIRECTION, 1);
      add_random_ticks(3, 0, 0);
      wait_quiet();

      // dark base color
      csr_write(REG_BASE_COLOR, 24'h000000);
      add_random_ticks(2, 0, 0);
      wait_quiet();

      // far end, tail behind again, uneven channels
      csr_write(REG_END_POSITION, 127);
      csr_write(REG_DIRECTION, 0);
      csr_write(REG_BASE_COLOR, 24'h804001);
      add_random_ticks(13, 0, 0);
      wait_quiet();

      // pull the end in behind the head: run is done, only status from here
      csr_write(REG_END_POSITION, 0);
      add_random_ticks(2, 0, 0);

      // random phases with fresh settings each time
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_quiet();
         if (phase < RANDOM_PHASES / 3) begin
            send_idle_pct <= 29;
            recv_idle_pct <= 47;
         end else if (phase < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct <= 47;
            recv_idle_pct <= 29;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         case ($urandom_range(0, 3))
            0: color_pick = 24'h000000;
            1: color_pick = 24'hffffff;
            default: color_pick = COLOR_W'($urandom);
         endcase
         csr_write(REG_BASE_COLOR, color_pick);
         csr_write(REG_END_POSITION, ($urandom_range(0, 99) < 60) ? 127 : $urandom_range(0, 127));
         csr_write(REG_DIRECTION, $urandom_range(0, 1));
         add_random_ticks(PHASE_ITEMS, 12, 6);
         // hold the result side off while ticks keep coming, so the input stalls
         if (phase == 1) begin
            hold_arm <= 1'b1;
            do @(posedge clock);
            while (hold_left == 0);
            hold_arm <= 1'b0;
         end
      end
      wait_quiet();

      if (expected_writes.size() != 0) begin
         report_mismatch("results never delivered", expected_writes.size(), 0);
      end
      $display("run: %0d items (%0d ticks), %0d results checked, %0d of them status only",
               items_accepted, ticks_accepted, checked_total, status_seen);
      $display("run: %0d register writes, head reached %0d, %0d mismatches",
               csr_writes, head_peak, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lcc_pkg.sv
rtl/lcc_req_if.sv
rtl/lcc_rsp_if.sv
rtl/lcc_ram.sv
rtl/lcc_tail_unit.sv
rtl/lcc_csr.sv
rtl/led_comet_tail_chaser_unit.sv
sim/tb_led_comet_tail_chaser_unit.sv
